### rtl/rhst_pkg.sv
`default_nettype none
package rhst_pkg;
  localparam int TABLE_SLOTS = 1024;
  localparam int SLOT_BITS   = $clog2(TABLE_SLOTS);
  localparam int CNT_BITS    = SLOT_BITS + 1;
  localparam int DIST_BITS   = SLOT_BITS + 1;
  localparam int MEMBER_BITS = 16;
  localparam int KEY_BITS    = 64;
  localparam int HASH_BITS   = 32;
  localparam int KEY_BYTES   = KEY_BITS / 8;
  localparam int BYTE_BITS   = $clog2(KEY_BYTES);
  localparam int FILL_BITS   = 10;

  localparam logic [HASH_BITS-1:0] FNV_BASIS = 32'd2166136261;
  localparam logic [HASH_BITS-1:0] FNV_PRIME = 32'd16777619;
  localparam logic [FILL_BITS-1:0] FILL_RESET = 10'd768;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_FIND   = 2'd1,
    REQ_CLEAR  = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_PRESENT  = 3'd1,
    ST_HIT      = 3'd2,
    ST_MISS     = 3'd3,
    ST_FULL     = 3'd4,
    ST_CLEARED  = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_LK_RD,
    S_LK_CHK,
    S_PL_RD,
    S_PL_CHK
  } state_t;

  typedef struct packed {
    logic [DIST_BITS-1:0]   distance;
    logic [MEMBER_BITS-1:0] member;
    logic [KEY_BITS-1:0]    key;
    logic [HASH_BITS-1:0]   hash;
  } entry_t;
endpackage
`default_nettype wire

### rtl/rhst_hash.sv
`default_nettype none
module rhst_hash (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  input  wire logic [rhst_pkg::KEY_BITS-1:0]  key,
  output logic                                done,
  output logic [rhst_pkg::HASH_BITS-1:0]      hash
);
  logic                               busy_r, busy_nxt;
  logic                               done_r, done_nxt;
  logic [rhst_pkg::BYTE_BITS-1:0]     cnt_r, cnt_nxt;
  logic [rhst_pkg::HASH_BITS-1:0]     h_r, h_nxt;
  logic [rhst_pkg::KEY_BITS-1:0]      key_r, key_nxt;

  // One FNV-1a round per cycle through a single truncated multiplier.
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    h_nxt    = h_r;
    key_nxt  = key_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      h_nxt    = rhst_pkg::FNV_BASIS;
      key_nxt  = key;
    end else if (busy_r) begin
      h_nxt   = rhst_pkg::HASH_BITS'((h_r ^ {24'd0, key_r[7:0]}) * rhst_pkg::FNV_PRIME);
      key_nxt = key_r >> 8;
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == rhst_pkg::BYTE_BITS'(rhst_pkg::KEY_BYTES - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    h_r   <= h_nxt;
    key_r <= key_nxt;
  end

  assign done = done_r;
  assign hash = (h_r == '0) ? rhst_pkg::HASH_BITS'(1) : h_r;
endmodule
`default_nettype wire

### rtl/robin_hood_symbol_table_unit.sv
`default_nettype none
// Find: the key is hashed, then each probed slot is read and checked (S_LK_RD, S_LK_CHK); the strobe follows.
// Insert: as find, then each slot walked while placing the entry is read and checked (S_PL_RD, S_PL_CHK).
// Clear: one slot per cycle across all 1024 slots, then the result strobe.
// Throughput: one request at a time; start is taken only while busy is low.
// Reset: synchronous; a pass over every slot empties the slot memory, busy stays high.
// Results cannot be stalled: each appears on out_valid for exactly one cycle.
module robin_hood_symbol_table_unit (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [1:0]                        in_req_type,
  input  wire logic [rhst_pkg::KEY_BITS-1:0]     in_symbol_key,
  input  wire logic [15:0]                       in_member_id,
  output logic                                   out_valid,
  output logic [2:0]                             out_status,
  output logic [15:0]                            out_member_out,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [2:0]                        paddr,
  input  wire logic [31:0]                       pwdata,
  output logic [31:0]                            prdata,
  output logic                                   pready
);
  rhst_pkg::state_t                    state_r, state_nxt;
  logic [rhst_pkg::SLOT_BITS-1:0]      slot_r, slot_nxt;
  logic [rhst_pkg::DIST_BITS-1:0]      dist_r, dist_nxt;
  logic [rhst_pkg::CNT_BITS-1:0]       n_r, n_nxt;
  logic [rhst_pkg::CNT_BITS-1:0]       count_r, count_nxt;
  logic                                report_r, report_nxt;
  logic                                is_ins_r, is_ins_nxt;
  logic [rhst_pkg::HASH_BITS-1:0]      ch_r, ch_nxt;
  logic [rhst_pkg::KEY_BITS-1:0]       ck_r, ck_nxt;
  logic [rhst_pkg::MEMBER_BITS-1:0]    cm_r, cm_nxt;
  logic [rhst_pkg::FILL_BITS-1:0]      fill_r;
  logic                                ov_r, ov_nxt;
  rhst_pkg::status_t                   os_r, os_nxt;
  logic [rhst_pkg::MEMBER_BITS-1:0]    om_r, om_nxt;

  rhst_pkg::entry_t                    mem [rhst_pkg::TABLE_SLOTS];
  rhst_pkg::entry_t                    rd_q, wr_d;
  logic                                we;

  logic                                hash_start, hash_done;
  logic [rhst_pkg::HASH_BITS-1:0]      hash_val;
  logic                                accept, last_n, take, full;

  rhst_hash u_hash (
    .clk   (clk),
    .rst_n (rst_n),
    .start (hash_start),
    .key   (ck_r),
    .done  (hash_done),
    .hash  (hash_val)
  );

  always_ff @(posedge clk) begin
    if (we) begin
      mem[slot_r] <= wr_d;
    end
    rd_q <= mem[slot_r];
  end

  assign accept = start && (state_r == rhst_pkg::S_IDLE);
  assign last_n = (n_r == rhst_pkg::CNT_BITS'(rhst_pkg::TABLE_SLOTS - 1));
  // The carried entry takes this slot when it is empty or the resident is richer.
  assign take   = (rd_q.hash == '0) || (dist_r > rd_q.distance);
  assign full   = (count_r >= {1'b0, fill_r}) ||
                  (count_r >= rhst_pkg::CNT_BITS'(rhst_pkg::TABLE_SLOTS));

  always_comb begin
    state_nxt  = state_r;
    slot_nxt   = slot_r;
    dist_nxt   = dist_r;
    n_nxt      = n_r;
    count_nxt  = count_r;
    report_nxt = report_r;
    is_ins_nxt = is_ins_r;
    ch_nxt     = ch_r;
    ck_nxt     = ck_r;
    cm_nxt     = cm_r;
    ov_nxt     = 1'b0;
    os_nxt     = os_r;
    om_nxt     = '0;
    we         = 1'b0;
    wr_d       = '{distance: dist_r, member: cm_r, key: ck_r, hash: ch_r};
    hash_start = 1'b0;
    unique case (state_r)
      rhst_pkg::S_CLEAR: begin
        we        = 1'b1;
        wr_d.hash = '0;
        slot_nxt  = slot_r + 1'b1;
        if (slot_r == rhst_pkg::SLOT_BITS'(rhst_pkg::TABLE_SLOTS - 1)) begin
          state_nxt = rhst_pkg::S_IDLE;
          count_nxt = '0;
          ov_nxt    = report_r;
          os_nxt    = rhst_pkg::ST_CLEARED;
        end
      end
      rhst_pkg::S_IDLE: begin
        if (accept) begin
          ck_nxt     = in_symbol_key;
          cm_nxt     = in_member_id[rhst_pkg::MEMBER_BITS-1:0];
          is_ins_nxt = (in_req_type == rhst_pkg::REQ_INSERT);
          unique case (in_req_type)
            rhst_pkg::REQ_INSERT, rhst_pkg::REQ_FIND: begin
              state_nxt = rhst_pkg::S_HASH;
            end
            rhst_pkg::REQ_CLEAR: begin
              state_nxt  = rhst_pkg::S_CLEAR;
              slot_nxt   = '0;
              report_nxt = 1'b1;
            end
            default: begin
              ov_nxt = 1'b1;
              os_nxt = rhst_pkg::ST_MISS;
            end
          endcase
        end
      end
      rhst_pkg::S_HASH: begin
        hash_start = (ch_r == '0) && !hash_done && (n_r == '0);
        n_nxt      = '1;
        if (hash_done) begin
          ch_nxt    = hash_val;
          slot_nxt  = hash_val[rhst_pkg::SLOT_BITS-1:0];
          dist_nxt  = '0;
          n_nxt     = '0;
          state_nxt = rhst_pkg::S_LK_RD;
        end
      end
      rhst_pkg::S_LK_RD: begin
        state_nxt = rhst_pkg::S_LK_CHK;
      end
      rhst_pkg::S_LK_CHK: begin
        if (!take && rd_q.hash == ch_r && rd_q.key == ck_r) begin
          state_nxt = rhst_pkg::S_IDLE;
          ov_nxt    = 1'b1;
          os_nxt    = is_ins_r ? rhst_pkg::ST_PRESENT : rhst_pkg::ST_HIT;
          om_nxt    = rd_q.member;
        end else if (take || last_n) begin
          if (!is_ins_r) begin
            state_nxt = rhst_pkg::S_IDLE;
            ov_nxt    = 1'b1;
            os_nxt    = rhst_pkg::ST_MISS;
          end else if (full) begin
            state_nxt = rhst_pkg::S_IDLE;
            ov_nxt    = 1'b1;
            os_nxt    = rhst_pkg::ST_FULL;
          end else begin
            state_nxt = rhst_pkg::S_PL_RD;
            slot_nxt  = ch_r[rhst_pkg::SLOT_BITS-1:0];
            dist_nxt  = '0;
            n_nxt     = '0;
          end
        end else begin
          state_nxt = rhst_pkg::S_LK_RD;
          slot_nxt  = slot_r + 1'b1;
          dist_nxt  = dist_r + 1'b1;
          n_nxt     = n_r + 1'b1;
        end
      end
      rhst_pkg::S_PL_RD: begin
        state_nxt = rhst_pkg::S_PL_CHK;
      end
      rhst_pkg::S_PL_CHK: begin
        dist_nxt = dist_r + 1'b1;
        if (take) begin
          we       = 1'b1;
          ch_nxt   = rd_q.hash;
          ck_nxt   = rd_q.key;
          cm_nxt   = rd_q.member;
          dist_nxt = rd_q.distance + 1'b1;
        end
        slot_nxt = slot_r + 1'b1;
        n_nxt    = n_r + 1'b1;
        if ((take && rd_q.hash == '0) || last_n) begin
          state_nxt = rhst_pkg::S_IDLE;
          count_nxt = count_r + 1'b1;
          ov_nxt    = 1'b1;
          os_nxt    = rhst_pkg::ST_INSERTED;
        end else begin
          state_nxt = rhst_pkg::S_PL_RD;
        end
      end
      default: begin
        state_nxt = rhst_pkg::S_IDLE;
      end
    endcase
    // The hash unit is launched in the first S_HASH cycle, once the accepted key is registered.
    if (accept && (in_req_type == rhst_pkg::REQ_INSERT ||
                   in_req_type == rhst_pkg::REQ_FIND)) begin
      ch_nxt = '1;
      n_nxt  = '0;
    end
    if (state_r == rhst_pkg::S_HASH) begin
      hash_start = (n_r == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= rhst_pkg::S_CLEAR;
      slot_r   <= '0;
      n_r      <= '0;
      count_r  <= '0;
      report_r <= 1'b0;
      ov_r     <= 1'b0;
      fill_r   <= rhst_pkg::FILL_RESET;
    end else begin
      state_r  <= state_nxt;
      slot_r   <= slot_nxt;
      n_r      <= n_nxt;
      count_r  <= count_nxt;
      report_r <= (state_nxt == rhst_pkg::S_CLEAR) ? report_nxt : 1'b0;
      ov_r     <= ov_nxt;
      if (psel && penable && pwrite && (paddr[2] == 1'b0)) begin
        fill_r <= pwdata[rhst_pkg::FILL_BITS-1:0];
      end
    end
    dist_r   <= dist_nxt;
    is_ins_r <= is_ins_nxt;
    ch_r     <= ch_nxt;
    ck_r     <= ck_nxt;
    cm_r     <= cm_nxt;
    os_r     <= os_nxt;
    om_r     <= om_nxt;
  end

  assign busy           = (state_r != rhst_pkg::S_IDLE);
  assign out_valid      = ov_r;
  assign out_status     = os_r;
  assign out_member_out = 16'(om_r);
  assign pready         = 1'b1;
  assign prdata         = (paddr[2] == 1'b0) ? {22'd0, fill_r} : 32'd0;
endmodule
`default_nettype wire
